// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants for the stable priority queue
// Request, response and slot layouts, request and status codes, FSM states.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 16;
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2
  } spq_mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } spq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_RM_SCAN
  } spq_state_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]          target_id;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [ID_W-1:0]          entry_id;
    logic signed [PRIO_W-1:0] entry_priority;
    logic [OCC_W-1:0]         occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
  } spq_slot_t;

endpackage

// File: rtl/stable_priority_queue_with_ids.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_with_ids - sorted task queue with assigned ids
// Entries kept highest priority first in one slot RAM; insert, pop, remove.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// beat appears on rsp with done high for one cycle as busy drops, and must be
// captured then since it cannot be held off. The entries live in one slot RAM
// with one write and one registered read port, and every operation walks it
// one slot per cycle: an insert walks from the tail down to its place, a pop
// or remove-by-id scans the whole queue while closing the gap, and a refused
// insert, an empty pop or remove, or an unknown mode finishes straight from
// idle without raising busy. The single RAM read port is what sets this pace.
module stable_priority_queue_with_ids
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  spq_req_t req,
  output logic     busy,
  output logic     done,
  output spq_rsp_t rsp
);

  spq_state_t state, state_next;

  spq_req_t         op, op_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [ID_W-1:0]  next_id, next_id_next;
  logic [CNT_W-1:0] pos, pos_next;         // insert: slot being filled
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next;   // scan: next slot to read
  logic             chk_vld, chk_vld_next; // scan: read data returning
  logic [IDX_W-1:0] chk_idx, chk_idx_next;
  logic             found, found_next;
  spq_slot_t        hit_slot, hit_slot_next;
  logic             done_next;
  spq_rsp_t         rsp_next;

  // slot RAM
  spq_slot_t        mem [CAPACITY];
  spq_slot_t        mem_rdata;
  spq_slot_t        mem_wdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  logic [ID_W-1:0] id_inc;
  spq_slot_t       new_slot;
  logic            match_now;
  logic            last_chk;

  assign id_inc   = (next_id == {ID_W{1'b1}}) ? ID_W'(1) : next_id + ID_W'(1);
  assign new_slot = '{id: next_id, prio: op.priority_req};
  assign match_now = (op.mode == MODE_POP) || (mem_rdata.id == op.target_id);
  assign last_chk  = (CNT_W'(chk_idx) == held_count - CNT_W'(1));

  always_comb begin
    state_next      = state;
    op_next         = op;
    held_count_next = held_count;
    next_id_next    = next_id;
    pos_next        = pos;
    rd_ptr_next     = rd_ptr;
    chk_vld_next    = 1'b0;
    chk_idx_next    = chk_idx;
    found_next      = found;
    hit_slot_next   = hit_slot;
    done_next       = 1'b0;
    rsp_next        = rsp;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = new_slot;
    mem_raddr       = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next = req;
          case (req.mode)
            MODE_INSERT: begin
              if (held_count >= CNT_W'(CAPACITY)) begin
                done_next = 1'b1;
                rsp_next  = '{status: ST_FULL, entry_id: '0, entry_priority: '0,
                              occupancy: OCC_W'(held_count)};
              end else begin
                pos_next   = held_count;
                state_next = S_INS_RD;
              end
            end
            MODE_POP, MODE_REMOVE: begin
              if (held_count == '0) begin
                done_next = 1'b1;
                rsp_next  = '{status: ST_MISS, entry_id: '0, entry_priority: '0,
                              occupancy: OCC_W'(held_count)};
              end else begin
                rd_ptr_next = '0;
                found_next  = 1'b0;
                state_next  = S_RM_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
              rsp_next  = '{status: ST_MISS, entry_id: '0, entry_priority: '0,
                            occupancy: OCC_W'(held_count)};
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (pos == '0) begin
          mem_we          = 1'b1;
          mem_waddr       = '0;
          mem_wdata       = new_slot;
          held_count_next = held_count + CNT_W'(1);
          next_id_next    = id_inc;
          done_next       = 1'b1;
          rsp_next        = '{status: ST_DONE, entry_id: next_id,
                              entry_priority: op.priority_req,
                              occupancy: OCC_W'(held_count + CNT_W'(1))};
          state_next      = S_IDLE;
        end else begin
          mem_raddr  = IDX_W'(pos - CNT_W'(1));
          state_next = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(pos);
        // equal priority stays ahead of the new entry
        if ($signed(mem_rdata.prio) >= $signed(op.priority_req)) begin
          mem_wdata       = new_slot;
          held_count_next = held_count + CNT_W'(1);
          next_id_next    = id_inc;
          done_next       = 1'b1;
          rsp_next        = '{status: ST_DONE, entry_id: next_id,
                              entry_priority: op.priority_req,
                              occupancy: OCC_W'(held_count + CNT_W'(1))};
          state_next      = S_IDLE;
        end else begin
          mem_wdata = mem_rdata;
          pos_next  = pos - CNT_W'(1);
          if (pos == CNT_W'(1)) begin
            state_next = S_INS_RD;
          end else begin
            // read the next lower slot while shifting this one up
            mem_raddr = IDX_W'(pos - CNT_W'(2));
          end
        end
      end

      S_RM_SCAN: begin
        if (rd_ptr < held_count) begin
          mem_raddr    = IDX_W'(rd_ptr);
          chk_vld_next = 1'b1;
          chk_idx_next = IDX_W'(rd_ptr);
          rd_ptr_next  = rd_ptr + CNT_W'(1);
        end
        if (chk_vld) begin
          if (found) begin
            // close the gap left by the removed entry
            mem_we    = 1'b1;
            mem_waddr = chk_idx - IDX_W'(1);
            mem_wdata = mem_rdata;
          end else if (match_now) begin
            found_next    = 1'b1;
            hit_slot_next = mem_rdata;
          end
          if (last_chk) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (found) begin
              held_count_next = held_count - CNT_W'(1);
              rsp_next = '{status: ST_DONE, entry_id: hit_slot.id,
                           entry_priority: hit_slot.prio,
                           occupancy: OCC_W'(held_count - CNT_W'(1))};
            end else if (match_now) begin
              held_count_next = held_count - CNT_W'(1);
              rsp_next = '{status: ST_DONE, entry_id: mem_rdata.id,
                           entry_priority: mem_rdata.prio,
                           occupancy: OCC_W'(held_count - CNT_W'(1))};
            end else begin
              rsp_next = '{status: ST_MISS, entry_id: '0, entry_priority: '0,
                           occupancy: OCC_W'(held_count)};
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      next_id    <= ID_W'(1);
      chk_vld    <= 1'b0;
      found      <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      next_id    <= next_id_next;
      chk_vld    <= chk_vld_next;
      found      <= found_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    pos      <= pos_next;
    rd_ptr   <= rd_ptr_next;
    chk_idx  <= chk_idx_next;
    hit_slot <= hit_slot_next;
    rsp      <= rsp_next;
  end

  assign busy = (state != S_IDLE);

endmodule
